/* design/plao_pkg.sv */
// Shared types, widths and helpers for the polygon loop area / orientation block.
// No dependencies; compiled first.
package plao_pkg;

    // Field widths of the channel words
    localparam int FIELD_BITS     = 24;
    localparam int AREA_BITS      = 64;
    localparam int TOL_BITS       = 23;
    localparam int EPS_BITS       = 62;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 62;

    // Significant coordinate bits (sign extended from here)
    localparam int COORD_BITS = 24;

    // Derived datapath widths
    localparam int DIFF_BITS  = COORD_BITS + 1;      // start - end style differences
    localparam int LIN_BITS   = COORD_BITS + 2;      // 2*mid - start - end
    localparam int DSQ_BITS   = 2 * DIFF_BITS;       // square of a difference
    localparam int LSQ_BITS   = 2 * LIN_BITS;        // square of a midpoint deviation
    localparam int PROD_BITS  = 2 * COORD_BITS;      // one cross term
    localparam int CROSS_BITS = 2 * COORD_BITS + 1;  // cross product of one edge
    localparam int TSQ_BITS   = 2 * TOL_BITS;        // tolerance squared
    localparam int CMP_RAW    = LSQ_BITS + 1;
    localparam int CMP_BITS   = (CMP_RAW > TSQ_BITS + 2) ? CMP_RAW : TSQ_BITS + 2;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [AREA_BITS-1:0]  area_t;

    // Register indexes of the configuration port
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CHECK_LINEARITY = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_GAP_TOLERANCE   = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_AREA_EPSILON    = 2'd2;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_NOT_STRAIGHT = 2'd1,
        ST_GAP          = 2'd2,
        ST_NOT_CLOSED   = 2'd3
    } plao_status_t;

    typedef enum logic [1:0] {
        OR_COLLINEAR = 2'd0,
        OR_CCW       = 2'd1,
        OR_CW        = 2'd2
    } plao_orient_t;

    localparam area_t AREA_MAX = {1'b0, {(AREA_BITS-1){1'b1}}};
    localparam area_t AREA_MIN = {1'b1, {(AREA_BITS-1){1'b0}}};

    // Saturating signed add at the area width
    function automatic area_t sat_add(input area_t a, input area_t b);
        logic signed [AREA_BITS:0] sum;
        area_t res;
        sum = {a[AREA_BITS-1], a} + {b[AREA_BITS-1], b};
        if (sum[AREA_BITS] != sum[AREA_BITS-1])
            res = sum[AREA_BITS] ? AREA_MIN : AREA_MAX;
        else
            res = sum[AREA_BITS-1:0];
        return res;
    endfunction

endpackage

/* design/plao_if.sv */
// Valid/ready channel interfaces: edge words in, loop result words out.
// Depends on plao_pkg.
interface plao_edge_if;
    import plao_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [FIELD_BITS-1:0] start_x;
    logic [FIELD_BITS-1:0] start_y;
    logic [FIELD_BITS-1:0] end_x;
    logic [FIELD_BITS-1:0] end_y;
    logic [FIELD_BITS-1:0] mid_x;
    logic [FIELD_BITS-1:0] mid_y;
    logic                  loop_end;
    logic                  face_end;

    modport source (
        output valid, start_x, start_y, end_x, end_y, mid_x, mid_y, loop_end, face_end,
        input  ready
    );
    modport sink (
        input  valid, start_x, start_y, end_x, end_y, mid_x, mid_y, loop_end, face_end,
        output ready
    );
endinterface

interface plao_result_if;
    import plao_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [1:0]           loop_status;
    logic [AREA_BITS-1:0] loop_double_area;
    logic [1:0]           loop_orientation;
    logic                 face_valid;
    logic [AREA_BITS-1:0] face_double_area;
    logic [1:0]           face_status;
    logic                 face_standard;

    modport source (
        output valid, loop_status, loop_double_area, loop_orientation,
               face_valid, face_double_area, face_status, face_standard,
        input  ready
    );
    modport sink (
        input  valid, loop_status, loop_double_area, loop_orientation,
               face_valid, face_double_area, face_status, face_standard,
        output ready
    );
endinterface

/* design/polygon_loop_area_orientation_top.sv */
// Polygon loop shoelace area, orientation and closure checker (top level).
// Depends on plao_pkg and the channel interfaces in plao_if.sv.
//
//   channel     dir  handshake      word
//   edge_in     in   valid/ready    one directed edge (start, end, mid, loop_end, face_end)
//   result_out  out  valid/ready    one loop report, plus the face summary on face_end
//   cfg         in   cfg_wr_en      register write, index cfg_index, data cfg_data
//
// One edge is taken per cycle unless the output is held. The datapath is six
// register stages: input, products, squared-distance compares, loop accumulator,
// orientation, and the face accumulator which is also the output register. Reset
// clears all control and accumulator state and loads the register defaults. When
// the output word is held by the sink the whole pipeline holds and edge_in.ready
// drops.
module polygon_loop_area_orientation_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    plao_edge_if.sink                            edge_in,
    plao_result_if.source                        result_out,
    input  logic                                 cfg_wr_en,
    input  logic [plao_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [plao_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import plao_pkg::*;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic                check_lin_reg;
    logic [TOL_BITS-1:0] gap_tol_reg;
    logic [EPS_BITS-1:0] area_eps_reg;
    logic [TSQ_BITS-1:0] tol_sq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            check_lin_reg <= 1'b1;
            gap_tol_reg   <= TOL_BITS'(1);
            area_eps_reg  <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_CHECK_LINEARITY: check_lin_reg <= cfg_data[0];
                CFG_GAP_TOLERANCE:   gap_tol_reg   <= cfg_data[TOL_BITS-1:0];
                CFG_AREA_EPSILON:    area_eps_reg  <= cfg_data[EPS_BITS-1:0];
                default:             ;
            endcase
        end
    end

    // tolerance squared, refreshed every cycle from the register
    always_ff @(posedge clk)
    begin
        tol_sq_reg <= gap_tol_reg * gap_tol_reg;
    end

    // ---------------------------------------------------------------
    // Pipeline advance: hold everything while the output word waits
    // ---------------------------------------------------------------
    logic out_valid_reg;
    logic adv;
    logic accept;

    assign adv           = !out_valid_reg || result_out.ready;
    assign edge_in.ready = adv;
    assign accept        = edge_in.valid && adv;

    coord_t in_sx, in_sy, in_ex, in_ey, in_mx, in_my;
    assign in_sx = edge_in.start_x[COORD_BITS-1:0];
    assign in_sy = edge_in.start_y[COORD_BITS-1:0];
    assign in_ex = edge_in.end_x[COORD_BITS-1:0];
    assign in_ey = edge_in.end_y[COORD_BITS-1:0];
    assign in_mx = edge_in.mid_x[COORD_BITS-1:0];
    assign in_my = edge_in.mid_y[COORD_BITS-1:0];

    // ---------------------------------------------------------------
    // Intake tracking: first point and previous end of the current loop
    // ---------------------------------------------------------------
    logic   have_first_reg;
    coord_t first_x_reg, first_y_reg;
    coord_t last_x_reg, last_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_first_reg <= 1'b0;
            first_x_reg    <= '0;
            first_y_reg    <= '0;
            last_x_reg     <= '0;
            last_y_reg     <= '0;
        end
        else if (accept)
        begin
            if (edge_in.loop_end)
            begin
                have_first_reg <= 1'b0;
                first_x_reg    <= '0;
                first_y_reg    <= '0;
                last_x_reg     <= '0;
                last_y_reg     <= '0;
            end
            else
            begin
                have_first_reg <= 1'b1;
                if (!have_first_reg)
                begin
                    first_x_reg <= in_sx;
                    first_y_reg <= in_sy;
                end
                last_x_reg <= in_ex;
                last_y_reg <= in_ey;
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: input register
    // ---------------------------------------------------------------
    logic   s1_valid_reg;
    coord_t s1_sx_reg, s1_sy_reg, s1_ex_reg, s1_ey_reg, s1_mx_reg, s1_my_reg;
    coord_t s1_lx_reg, s1_ly_reg, s1_fx_reg, s1_fy_reg;
    logic   s1_gap_en_reg, s1_lend_reg, s1_fend_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (adv)
            s1_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_sx_reg     <= in_sx;
            s1_sy_reg     <= in_sy;
            s1_ex_reg     <= in_ex;
            s1_ey_reg     <= in_ey;
            s1_mx_reg     <= in_mx;
            s1_my_reg     <= in_my;
            s1_lx_reg     <= last_x_reg;
            s1_ly_reg     <= last_y_reg;
            s1_fx_reg     <= have_first_reg ? first_x_reg : in_sx;
            s1_fy_reg     <= have_first_reg ? first_y_reg : in_sy;
            s1_gap_en_reg <= have_first_reg;
            s1_lend_reg   <= edge_in.loop_end;
            s1_fend_reg   <= edge_in.face_end;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: differences and products
    // ---------------------------------------------------------------
    logic signed [LIN_BITS-1:0]  lin_dx, lin_dy;
    logic signed [DIFF_BITS-1:0] gap_dx, gap_dy, cls_dx, cls_dy;

    always_comb
    begin
        lin_dx = {s1_mx_reg[COORD_BITS-1], s1_mx_reg, 1'b0}
               - LIN_BITS'(s1_sx_reg) - LIN_BITS'(s1_ex_reg);
        lin_dy = {s1_my_reg[COORD_BITS-1], s1_my_reg, 1'b0}
               - LIN_BITS'(s1_sy_reg) - LIN_BITS'(s1_ey_reg);
        gap_dx = DIFF_BITS'(s1_sx_reg) - DIFF_BITS'(s1_lx_reg);
        gap_dy = DIFF_BITS'(s1_sy_reg) - DIFF_BITS'(s1_ly_reg);
        cls_dx = DIFF_BITS'(s1_ex_reg) - DIFF_BITS'(s1_fx_reg);
        cls_dy = DIFF_BITS'(s1_ey_reg) - DIFF_BITS'(s1_fy_reg);
    end

    logic                        s2_valid_reg;
    logic signed [PROD_BITS-1:0] s2_xa_reg, s2_xb_reg;
    logic signed [LSQ_BITS-1:0]  s2_lsx_reg, s2_lsy_reg;
    logic signed [DSQ_BITS-1:0]  s2_gsx_reg, s2_gsy_reg, s2_csx_reg, s2_csy_reg;
    logic                        s2_gap_en_reg, s2_lend_reg, s2_fend_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (adv)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_xa_reg     <= s1_sx_reg * s1_ey_reg;
            s2_xb_reg     <= s1_sy_reg * s1_ex_reg;
            s2_lsx_reg    <= lin_dx * lin_dx;
            s2_lsy_reg    <= lin_dy * lin_dy;
            s2_gsx_reg    <= gap_dx * gap_dx;
            s2_gsy_reg    <= gap_dy * gap_dy;
            s2_csx_reg    <= cls_dx * cls_dx;
            s2_csy_reg    <= cls_dy * cls_dy;
            s2_gap_en_reg <= s1_gap_en_reg;
            s2_lend_reg   <= s1_lend_reg;
            s2_fend_reg   <= s1_fend_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: cross product and squared-distance compares
    // ---------------------------------------------------------------
    logic [CMP_BITS-1:0]          lin_sq, gap_sq, cls_sq, tol2, tol2x4;
    logic signed [CROSS_BITS-1:0] cross_next;
    plao_status_t                 edge_err;
    logic                         lin_bad, gap_bad;

    always_comb
    begin
        lin_sq = CMP_BITS'($unsigned(s2_lsx_reg)) + CMP_BITS'($unsigned(s2_lsy_reg));
        gap_sq = CMP_BITS'($unsigned(s2_gsx_reg)) + CMP_BITS'($unsigned(s2_gsy_reg));
        cls_sq = CMP_BITS'($unsigned(s2_csx_reg)) + CMP_BITS'($unsigned(s2_csy_reg));
        tol2   = CMP_BITS'(tol_sq_reg);
        tol2x4 = CMP_BITS'({tol_sq_reg, 2'b00});
        cross_next = CROSS_BITS'(s2_xa_reg) - CROSS_BITS'(s2_xb_reg);
        lin_bad = check_lin_reg && (lin_sq > tol2x4);
        gap_bad = s2_gap_en_reg && (gap_sq > tol2);
        // linearity error takes precedence over the gap error
        priority if (lin_bad)
            edge_err = ST_NOT_STRAIGHT;
        else if (gap_bad)
            edge_err = ST_GAP;
        else
            edge_err = ST_OK;
    end

    logic                         s3_valid_reg;
    logic signed [CROSS_BITS-1:0] s3_cross_reg;
    plao_status_t                 s3_err_reg;
    logic                         s3_cls_bad_reg, s3_lend_reg, s3_fend_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else if (adv)
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_cross_reg   <= cross_next;
            s3_err_reg     <= edge_err;
            s3_cls_bad_reg <= cls_sq > tol2;
            s3_lend_reg    <= s2_lend_reg;
            s3_fend_reg    <= s2_fend_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stage 4: loop accumulator (saturating cross sum, first error)
    // ---------------------------------------------------------------
    area_t        cross_sum_reg;
    plao_status_t loop_err_reg;
    area_t        cross_sum_next, loop_area;
    plao_status_t loop_err_next, loop_stat;

    always_comb
    begin
        cross_sum_next = sat_add(cross_sum_reg, AREA_BITS'(s3_cross_reg));
        loop_err_next  = (loop_err_reg == ST_OK) ? s3_err_reg : loop_err_reg;
        // closure is tested only when the loop is still clean
        if (loop_err_next == ST_OK && s3_cls_bad_reg)
            loop_stat = ST_NOT_CLOSED;
        else
            loop_stat = loop_err_next;
        loop_area = (loop_stat == ST_OK) ? cross_sum_next : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cross_sum_reg <= '0;
            loop_err_reg  <= ST_OK;
        end
        else if (adv && s3_valid_reg)
        begin
            if (s3_lend_reg)
            begin
                cross_sum_reg <= '0;
                loop_err_reg  <= ST_OK;
            end
            else
            begin
                cross_sum_reg <= cross_sum_next;
                loop_err_reg  <= loop_err_next;
            end
        end
    end

    logic         s4_res_reg;
    plao_status_t s4_stat_reg;
    area_t        s4_area_reg;
    logic         s4_fend_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_res_reg <= 1'b0;
        else if (adv)
            s4_res_reg <= s3_valid_reg && s3_lend_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_stat_reg <= loop_stat;
            s4_area_reg <= loop_area;
            s4_fend_reg <= s3_fend_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stage 5: orientation against the collinear threshold
    // ---------------------------------------------------------------
    logic [AREA_BITS-1:0] area_mag;
    plao_orient_t         orient;

    always_comb
    begin
        area_mag = s4_area_reg[AREA_BITS-1] ? $unsigned(-s4_area_reg)
                                            : $unsigned(s4_area_reg);
        if (s4_stat_reg != ST_OK || area_mag <= AREA_BITS'(area_eps_reg))
            orient = OR_COLLINEAR;
        else if (s4_area_reg[AREA_BITS-1])
            orient = OR_CW;
        else
            orient = OR_CCW;
    end

    logic         s5_res_reg;
    plao_status_t s5_stat_reg;
    area_t        s5_area_reg;
    plao_orient_t s5_orient_reg;
    logic         s5_fend_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s5_res_reg <= 1'b0;
        else if (adv)
            s5_res_reg <= s4_res_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_stat_reg   <= s4_stat_reg;
            s5_area_reg   <= s4_area_reg;
            s5_orient_reg <= orient;
            s5_fend_reg   <= s4_fend_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stage 6: face accumulator and output register
    // ---------------------------------------------------------------
    area_t        face_sum_reg;
    plao_status_t face_err_reg;
    logic         face_std_reg;
    logic         outer_reg;
    area_t        face_sum_next;
    plao_status_t face_err_next;
    logic         face_std_next;

    always_comb
    begin
        face_sum_next = sat_add(face_sum_reg, s5_area_reg);
        face_err_next = (face_err_reg == ST_OK) ? s5_stat_reg : face_err_reg;
        // outer loop must be ccw, every later loop cw
        if (outer_reg)
            face_std_next = face_std_reg && (s5_orient_reg == OR_CCW);
        else
            face_std_next = face_std_reg && (s5_orient_reg == OR_CW);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            face_sum_reg <= '0;
            face_err_reg <= ST_OK;
            face_std_reg <= 1'b1;
            outer_reg    <= 1'b1;
        end
        else if (adv && s5_res_reg)
        begin
            if (s5_fend_reg)
            begin
                face_sum_reg <= '0;
                face_err_reg <= ST_OK;
                face_std_reg <= 1'b1;
                outer_reg    <= 1'b1;
            end
            else
            begin
                face_sum_reg <= face_sum_next;
                face_err_reg <= face_err_next;
                face_std_reg <= face_std_next;
                outer_reg    <= 1'b0;
            end
        end
    end

    plao_status_t out_stat_reg;
    area_t        out_area_reg;
    plao_orient_t out_orient_reg;
    logic         out_fvalid_reg;
    area_t        out_farea_reg;
    plao_status_t out_fstat_reg;
    logic         out_fstd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= s5_res_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_stat_reg   <= s5_stat_reg;
            out_area_reg   <= s5_area_reg;
            out_orient_reg <= s5_orient_reg;
            out_fvalid_reg <= s5_fend_reg;
            out_farea_reg  <= s5_fend_reg ? face_sum_next : '0;
            out_fstat_reg  <= s5_fend_reg ? face_err_next : ST_OK;
            out_fstd_reg   <= s5_fend_reg && face_std_next;
        end
    end

    assign result_out.valid            = out_valid_reg;
    assign result_out.loop_status      = out_stat_reg;
    assign result_out.loop_double_area = out_area_reg;
    assign result_out.loop_orientation = out_orient_reg;
    assign result_out.face_valid       = out_fvalid_reg;
    assign result_out.face_double_area = out_farea_reg;
    assign result_out.face_status      = out_fstat_reg;
    assign result_out.face_standard    = out_fstd_reg;

endmodule
